// ----- sv/pbmc_pkg.sv -----
// types, codes and reset values shared by the power bank mode controller
package pbmc_pkg;

  // mode codes
  localparam logic [2:0] MODE_INIT        = 3'd0;
  localparam logic [2:0] MODE_IDLE        = 3'd1;
  localparam logic [2:0] MODE_CHARGING    = 3'd2;
  localparam logic [2:0] MODE_DISCHARGING = 3'd3;
  localparam logic [2:0] MODE_PROTECT     = 3'd4;

  // fault bit positions
  localparam int FLT_LOW  = 0;
  localparam int FLT_OVER = 1;
  localparam int FLT_OC   = 2;
  localparam int FLT_TEMP = 3;

  // debounce counter limits
  localparam logic [1:0] DEB_MAX = 2'd3;
  localparam logic [1:0] DEB_ON  = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W           = 3;
  localparam int          CFG_DATA_W          = 16;
  localparam logic [2:0]  CFG_BAT_LOW_MV      = 3'd0;
  localparam logic [2:0]  CFG_BAT_OVER_MV     = 3'd1;
  localparam logic [2:0]  CFG_BAT_RECOVER_MV  = 3'd2;
  localparam logic [2:0]  CFG_BAT_FULL_MV     = 3'd3;
  localparam logic [2:0]  CFG_OVER_CURRENT_MA = 3'd4;
  localparam logic [2:0]  CFG_TEMP_LOW_C      = 3'd5;
  localparam logic [2:0]  CFG_TEMP_HIGH_C     = 3'd6;
  localparam logic [2:0]  CFG_TEMP_PROTECT_ON = 3'd7;

  // configuration reset values
  localparam logic [15:0] RST_BAT_LOW_MV      = 16'd3000;
  localparam logic [15:0] RST_BAT_OVER_MV     = 16'd4250;
  localparam logic [15:0] RST_BAT_RECOVER_MV  = 16'd3300;
  localparam logic [15:0] RST_BAT_FULL_MV     = 16'd4200;
  localparam logic [15:0] RST_OVER_CURRENT_MA = 16'd2500;
  localparam logic [7:0]  RST_TEMP_LOW_C      = 8'sd0;
  localparam logic [7:0]  RST_TEMP_HIGH_C     = 8'sd60;
  localparam logic        RST_TEMP_PROTECT_ON = 1'b1;

  typedef struct packed {
    logic [15:0]        battery_mv;
    logic [15:0]        output_ma;
    logic signed [7:0]  battery_temp;
    logic               input_seen;
    logic               load_seen;
    logic               pd_is_ready;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] faults;
    logic       charge_on;
    logic       output_on;
    logic       input_present;
    logic       load_present;
    logic       mode_changed;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        low_batt_mv;
    logic [15:0]        over_batt_mv;
    logic [15:0]        recover_batt_mv;
    logic [15:0]        full_batt_mv;
    logic [15:0]        over_current_ma;
    logic signed [7:0]  temp_low_c;
    logic signed [7:0]  temp_high_c;
    logic               temp_protect_on;
  } cfg_regs_t;

  typedef struct packed {
    logic [3:0] faults;
    logic       recoverable;
    logic       bat_full;
  } fault_info_t;

endpackage

// ----- sv/pbmc_cfg_regs.sv -----
// threshold and enable registers written through the configuration port
module pbmc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pbmc_pkg::cfg_regs_t              regs
);

  pbmc_pkg::cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.low_batt_mv     <= pbmc_pkg::RST_BAT_LOW_MV;
      regs_r.over_batt_mv    <= pbmc_pkg::RST_BAT_OVER_MV;
      regs_r.recover_batt_mv <= pbmc_pkg::RST_BAT_RECOVER_MV;
      regs_r.full_batt_mv    <= pbmc_pkg::RST_BAT_FULL_MV;
      regs_r.over_current_ma <= pbmc_pkg::RST_OVER_CURRENT_MA;
      regs_r.temp_low_c      <= pbmc_pkg::RST_TEMP_LOW_C;
      regs_r.temp_high_c     <= pbmc_pkg::RST_TEMP_HIGH_C;
      regs_r.temp_protect_on <= pbmc_pkg::RST_TEMP_PROTECT_ON;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbmc_pkg::CFG_BAT_LOW_MV:      regs_r.low_batt_mv     <= cfg_data;
        pbmc_pkg::CFG_BAT_OVER_MV:     regs_r.over_batt_mv    <= cfg_data;
        pbmc_pkg::CFG_BAT_RECOVER_MV:  regs_r.recover_batt_mv <= cfg_data;
        pbmc_pkg::CFG_BAT_FULL_MV:     regs_r.full_batt_mv    <= cfg_data;
        pbmc_pkg::CFG_OVER_CURRENT_MA: regs_r.over_current_ma <= cfg_data;
        pbmc_pkg::CFG_TEMP_LOW_C:      regs_r.temp_low_c      <= cfg_data[7:0];
        pbmc_pkg::CFG_TEMP_HIGH_C:     regs_r.temp_high_c     <= cfg_data[7:0];
        pbmc_pkg::CFG_TEMP_PROTECT_ON: regs_r.temp_protect_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/pbmc_fault_eval.sv -----
// threshold comparisons: fault flags, recovery and full-charge checks
module pbmc_fault_eval (
  input  pbmc_pkg::in_item_t    item,
  input  pbmc_pkg::cfg_regs_t   regs,
  output pbmc_pkg::fault_info_t info
);

  logic temp_bad;

  assign temp_bad = regs.temp_protect_on &&
                    (($signed(item.battery_temp) < $signed(regs.temp_low_c)) ||
                     ($signed(item.battery_temp) > $signed(regs.temp_high_c)));

  always_comb begin
    info.faults[pbmc_pkg::FLT_LOW]  = item.battery_mv < regs.low_batt_mv;
    info.faults[pbmc_pkg::FLT_OVER] = item.battery_mv > regs.over_batt_mv;
    info.faults[pbmc_pkg::FLT_OC]   = item.output_ma > regs.over_current_ma;
    info.faults[pbmc_pkg::FLT_TEMP] = temp_bad;
    info.recoverable = (item.battery_mv >= regs.recover_batt_mv) &&
                       (item.battery_mv <= regs.over_batt_mv) &&
                       (item.output_ma <= regs.over_current_ma) && !temp_bad;
    info.bat_full    = item.battery_mv >= regs.full_batt_mv;
  end

endmodule

// ----- sv/pbmc_mode_fsm.sv -----
// debounce counters and the five-state mode machine
module pbmc_mode_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  pbmc_pkg::in_item_t    item,
  input  pbmc_pkg::fault_info_t info,
  output pbmc_pkg::out_item_t   result
);

  logic [2:0] mode_r;
  logic [2:0] mode_nxt;
  logic [1:0] in_deb_r;
  logic [1:0] in_deb_nxt;
  logic [1:0] ld_deb_r;
  logic [1:0] ld_deb_nxt;
  logic       in_att;
  logic       ld_att;
  logic       fatal;
  logic       any_flt;
  logic       only_low;

  function automatic logic [1:0] deb_step(input logic [1:0] cnt, input logic seen);
    logic [1:0] r;
    if (seen) begin
      r = (cnt < pbmc_pkg::DEB_MAX) ? cnt + 2'd1 : cnt;
    end else begin
      r = (cnt != 2'd0) ? cnt - 2'd1 : 2'd0;
    end
    return r;
  endfunction

  assign in_deb_nxt = deb_step(in_deb_r, item.input_seen);
  assign ld_deb_nxt = deb_step(ld_deb_r, item.load_seen);
  assign in_att     = in_deb_nxt >= pbmc_pkg::DEB_ON;
  assign ld_att     = ld_deb_nxt >= pbmc_pkg::DEB_ON;

  assign any_flt  = |info.faults;
  assign fatal    = info.faults[pbmc_pkg::FLT_OVER] | info.faults[pbmc_pkg::FLT_OC] |
                    info.faults[pbmc_pkg::FLT_TEMP];
  assign only_low = info.faults[pbmc_pkg::FLT_LOW] && !fatal;

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      pbmc_pkg::MODE_INIT: begin
        mode_nxt = pbmc_pkg::MODE_IDLE;
      end
      pbmc_pkg::MODE_IDLE: begin
        if (in_att && item.pd_is_ready && !fatal) begin
          mode_nxt = pbmc_pkg::MODE_CHARGING;
        end else if (any_flt) begin
          mode_nxt = pbmc_pkg::MODE_PROTECT;
        end else if (ld_att) begin
          mode_nxt = pbmc_pkg::MODE_DISCHARGING;
        end
      end
      pbmc_pkg::MODE_CHARGING: begin
        if (fatal) begin
          mode_nxt = pbmc_pkg::MODE_PROTECT;
        end else if (!in_att || !item.pd_is_ready || info.bat_full) begin
          mode_nxt = pbmc_pkg::MODE_IDLE;
        end
      end
      pbmc_pkg::MODE_DISCHARGING: begin
        if (any_flt) begin
          mode_nxt = pbmc_pkg::MODE_PROTECT;
        end else if (in_att && item.pd_is_ready) begin
          mode_nxt = pbmc_pkg::MODE_CHARGING;
        end else if (!ld_att) begin
          mode_nxt = pbmc_pkg::MODE_IDLE;
        end
      end
      pbmc_pkg::MODE_PROTECT: begin
        // recovery wins over the low-battery charge path
        if (info.recoverable) begin
          mode_nxt = pbmc_pkg::MODE_IDLE;
        end else if (in_att && item.pd_is_ready && only_low) begin
          mode_nxt = pbmc_pkg::MODE_CHARGING;
        end
      end
      default: begin
        mode_nxt = pbmc_pkg::MODE_PROTECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pbmc_pkg::MODE_INIT;
      in_deb_r <= 2'd0;
      ld_deb_r <= 2'd0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      in_deb_r <= in_deb_nxt;
      ld_deb_r <= ld_deb_nxt;
    end
  end

  always_comb begin
    result.mode          = mode_nxt;
    result.faults        = info.faults;
    result.charge_on     = mode_nxt == pbmc_pkg::MODE_CHARGING;
    result.output_on     = mode_nxt == pbmc_pkg::MODE_DISCHARGING;
    result.input_present = in_att;
    result.load_present  = ld_att;
    result.mode_changed  = mode_nxt != mode_r;
  end

endmodule

// ----- sv/power_bank_mode_controller.sv -----
// top level of the power bank mode controller
//
// one tick of measurements (battery voltage, output current, temperature and
// the raw input, load and pd-ready samples) is a transfer on the in_ channel;
// each tick gives exactly one result transfer on the out_ channel carrying the
// new mode, the fault flags, the charge/output enables and debounced presence
// an accepted tick is held in the input register while the comparisons
// and the mode update run on it, and the result lands in the output
// register, which drives out_valid
// throughput is one tick per cycle unless the receiver stalls, set by the
// mode/debounce update loop; in_ready stays high while the output register is
// empty or is being emptied, so a stalled receiver holds at most two ticks in flight
// thresholds are written through the cfg_ port (always ready) and must only
// change while no tick is in flight
// synchronous active-low reset puts the mode into init, clears both debounce
// counters, loads the default thresholds and empties both registers
module power_bank_mode_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pbmc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pbmc_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbmc_pkg::cfg_regs_t   regs;
  pbmc_pkg::fault_info_t info;
  pbmc_pkg::in_item_t    s1_data_r;
  pbmc_pkg::out_item_t   result;
  pbmc_pkg::out_item_t   out_data_r;
  logic                  s1_vld_r;
  logic                  out_vld_r;
  logic                  advance;

  // tick moves from the input register into the output register
  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  pbmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  pbmc_fault_eval u_fault (
    .item (s1_data_r),
    .regs (regs),
    .info (info)
  );

  pbmc_mode_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_data_r),
    .info    (info),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

// ----- sv/pbmc_checker.sv -----
// port-level checks for the power bank mode controller, bound to the top level
module pbmc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pbmc_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // the enables never overlap and follow the mode
  a_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.charge_on == (out_data.mode == pbmc_pkg::MODE_CHARGING)) &&
                  (out_data.output_on == (out_data.mode == pbmc_pkg::MODE_DISCHARGING)))
    else $error("charge/output enable does not match mode");

  // init is left on the first tick and never re-entered
  a_no_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode != pbmc_pkg::MODE_INIT)
    else $error("result reports init mode");

  // charging is only reported with a debounced charger attached
  a_charge_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == pbmc_pkg::MODE_CHARGING |-> out_data.input_present)
    else $error("charging without charger input present");

endmodule

bind power_bank_mode_controller pbmc_checker u_pbmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
